// ----- rtl/bus_disk_controller_assert.svh -----
// Assertion macros for the bus disk controller checker.
// Used by bdc_checker; needs clk and rst_n in the including scope.
`ifndef BUS_DISK_CONTROLLER_ASSERT_SVH
`define BUS_DISK_CONTROLLER_ASSERT_SVH

// implication in the same cycle, off during reset
`define BDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, also checked through reset
`define BDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bdc_pkg.sv -----
// Shared types and constants for the bus disk controller.
// No dependencies.
`default_nettype none
package bdc_pkg;

  localparam int SECTOR_BYTES_DEF = 256;
  localparam int BUFFER_COUNT_DEF = 4;
  localparam int UNIT_COUNT       = 8;

  localparam logic [2:0] OP_SELECT = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_FILL   = 3'd3;
  localparam logic [2:0] OP_DRAIN  = 3'd4;
  localparam logic [2:0] OP_DONE   = 3'd5;

  localparam logic [2:0] PORT_DATA   = 3'd0;
  localparam logic [2:0] PORT_STATUS = 3'd1;
  localparam logic [2:0] PORT_RST_A  = 3'd2;
  localparam logic [2:0] PORT_RST_B  = 3'd4;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR3    = 3'd3;
  localparam logic [2:0] PH_RECV    = 3'd4;
  localparam logic [2:0] PH_SEND    = 3'd5;
  localparam logic [2:0] PH_WAIT_RD = 3'd6;
  localparam logic [2:0] PH_WAIT_WR = 3'd7;

  localparam logic [7:0] CMD_READ  = 8'h01;
  localparam logic [7:0] CMD_SEND  = 8'h02;
  localparam logic [7:0] CMD_RECV  = 8'h04;
  localparam logic [7:0] CMD_WRITE = 8'h08;

  localparam logic [7:0] STS_READY = 8'h01;
  localparam logic [7:0] STS_ERROR = 8'h08;
  localparam logic [7:0] STS_IDLE  = 8'h80;

  localparam logic [7:0] RC_NOT_READY = 8'h80;
  localparam logic [7:0] RC_READ_ERR  = 8'h10;
  localparam logic [7:0] RC_WRITE_ERR = 8'h40;
  localparam logic [7:0] BUS_FLOAT    = 8'hFF;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [2:0] CFG_SELECT   = 3'd0;
  localparam logic [2:0] CFG_SPC      = 3'd1;
  localparam logic [2:0] CFG_TOTAL    = 3'd2;
  localparam logic [2:0] CFG_IL_FACT  = 3'd3;
  localparam logic [2:0] CFG_IL_MASK  = 3'd4;
  localparam logic [2:0] CFG_UNITS    = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_HADDR, ST_CHECK,
    ST_CADDR, ST_CONT, ST_WIPE, ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic addr_load;
    logic check;
    logic cont;
    logic clear_en;
    logic wipe_en;
  } bdc_cmd_t;

  typedef struct packed {
    logic hdr_done;
    logic cont_req;
    logic check_pass;
    logic cmd_read;
    logic clear_last;
    logic wipe_last;
  } bdc_stat_t;

endpackage
`default_nettype wire

// ----- rtl/bdc_datapath.sv -----
// Datapath: protocol state, config registers, sector buffer memory, result registers.
// Depends on bdc_pkg; driven by bdc_ctrl commands.
`default_nettype none
module bdc_datapath import bdc_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire bdc_cmd_t    cmd,
  output bdc_stat_t        stat,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [2:0]  in_port,
  input  wire logic [7:0]  in_value,
  input  wire logic [7:0]  in_byte_index,
  input  wire logic        in_media_error,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_wdata,
  output logic [7:0]       out_read_data,
  output logic [1:0]       out_media_request,
  output logic [2:0]       out_media_unit,
  output logic [13:0]      out_media_sector,
  output logic [7:0]       out_media_byte
);
  localparam int IW    = $clog2(SECTOR_BYTES);
  localparam int CW    = IW + 1;
  localparam int DEPTH = BUFFER_COUNT * SECTOR_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [2:0]  BC3    = 3'(BUFFER_COUNT);
  localparam logic [10:0] SB_L   = 11'(SECTOR_BYTES);
  localparam logic [CW-1:0] SB_C = CW'(SECTOR_BYTES);

  // config
  logic [5:0]  selc_r;
  logic [2:0]  spc_r;
  logic [13:0] total_r;
  logic [3:0]  ifac_r, imask_r;
  logic [7:0]  units_r;

  // latched item
  logic [2:0] op_r, port_r;
  logic [7:0] val_r, bi_r;
  logic       merr_r;

  // protocol state
  logic [2:0]    phase_r, phase_nxt;
  logic [7:0]    hdr_r [4];
  logic [7:0]    hdr_nxt [4];
  logic          err_r, err_nxt;
  logic [7:0]    rc_r, rc_nxt;
  logic [IW-1:0] sidx_r, sidx_nxt;
  logic          sact_r, sact_nxt;
  logic [IW-1:0] ridx_r, ridx_nxt;
  logic          sel_r, sel_nxt;
  logic [13:0]   lsec_r;
  logic [AW-1:0] sweep_r;

  // results
  logic [7:0]  rd_r, rd_nxt, mb_r, mb_nxt;
  logic [1:0]  req_r, req_nxt;
  logic [2:0]  unit_r, unit_nxt;
  logic [13:0] sec_r, sec_nxt;

  // memory
  logic [7:0]    mem [DEPTH];
  logic [7:0]    q_r;
  logic [AW-1:0] ra, wa;
  logic          we;
  logic [7:0]    wd;

  logic [1:0]    bsel;
  logic [AW-1:0] base;
  logic [10:0]   logical;
  logic [13:0]   lsec_calc;
  logic [7:0]    prod;
  logic [13:0]   phys;
  logic [CW-1:0] sidx_inc, ridx_inc;
  logic          bi_ok;
  logic          unit_ok;
  logic [7:0]    status;

  always_comb begin
    bsel = hdr_r[1][7:6];
    for (int k = 0; k < 3; k++) begin
      if ({1'b0, bsel} >= BC3) begin
        bsel = bsel - BC3[1:0];
      end
    end
    base = AW'(bsel) * AW'(SECTOR_BYTES);
  end

  assign logical   = {hdr_r[2], 3'b000} + 11'(hdr_r[3][7:5]);
  assign lsec_calc = 14'(14'(logical) * 14'(spc_r)) + 14'(hdr_r[3][4:0]);
  assign prod      = lsec_r[3:0] * ifac_r;
  assign phys      = (lsec_r & ~{10'd0, imask_r}) | {10'd0, prod[3:0] & imask_r};
  assign sidx_inc  = CW'(sidx_r) + CW'(1);
  assign ridx_inc  = CW'(ridx_r) + CW'(1);
  assign bi_ok     = {3'b000, bi_r} < SB_L;
  assign unit_ok   = (4'(hdr_r[1][2:0]) < 4'(UNIT_COUNT)) && units_r[hdr_r[1][2:0]];

  always_comb begin
    status = (phase_r >= PH_WAIT_RD) ? 8'h00 : STS_READY;
    if (err_r) status = status | STS_ERROR;
    if (phase_r == PH_HDR0) status = status | STS_IDLE;
  end

  // memory read address follows the latched item
  always_comb begin
    if (op_r == OP_DRAIN) ra = base + AW'(bi_r);
    else ra = base + AW'(sidx_r);
  end

  always_comb begin
    phase_nxt = phase_r;
    for (int k = 0; k < 4; k++) hdr_nxt[k] = hdr_r[k];
    err_nxt  = err_r;
    rc_nxt   = rc_r;
    sidx_nxt = sidx_r;
    sact_nxt = sact_r;
    ridx_nxt = ridx_r;
    sel_nxt  = sel_r;
    rd_nxt   = rd_r;
    mb_nxt   = mb_r;
    req_nxt  = req_r;
    unit_nxt = unit_r;
    sec_nxt  = sec_r;
    stat     = '0;
    we = 1'b0;
    wa = '0;
    wd = 8'h00;

    stat.clear_last = sweep_r == AW'(DEPTH - 1);
    stat.wipe_last  = sweep_r == AW'(SECTOR_BYTES - 1);
    stat.cmd_read   = hdr_r[0][0];

    if (cmd.clear_en) begin
      we = 1'b1;
      wa = sweep_r;
    end else if (cmd.wipe_en) begin
      we = 1'b1;
      wa = base + sweep_r;
    end

    if (cmd.exec) begin
      rd_nxt   = 8'h00;
      mb_nxt   = 8'h00;
      req_nxt  = REQ_NONE;
      unit_nxt = 3'd0;
      sec_nxt  = 14'd0;
      unique case (op_r)
        OP_SELECT: sel_nxt = (units_r != 8'h00) && ({2'b00, selc_r} == val_r);
        OP_WRITE: begin
          if (sel_r) begin
            case (port_r) inside
              PORT_RST_A, PORT_RST_B: begin
                phase_nxt = PH_HDR0;
                for (int k = 0; k < 4; k++) hdr_nxt[k] = 8'h00;
                err_nxt  = 1'b0;
                rc_nxt   = 8'h00;
                sidx_nxt = '0;
                sact_nxt = 1'b0;
                ridx_nxt = '0;
              end
              PORT_DATA: begin
                if (phase_r <= PH_HDR3) begin
                  err_nxt = 1'b0;
                  rc_nxt  = 8'h00;
                  hdr_nxt[phase_r[1:0]] = val_r;
                  if (phase_r == PH_HDR3) begin
                    phase_nxt     = PH_HDR0;
                    stat.hdr_done = 1'b1;
                  end else begin
                    phase_nxt = phase_r + 3'd1;
                  end
                end else if (phase_r == PH_RECV) begin
                  we = 1'b1;
                  wa = base + AW'(ridx_r);
                  wd = val_r;
                  ridx_nxt = ridx_inc[IW-1:0];
                  if (ridx_inc >= SB_C) stat.cont_req = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        OP_READ: begin
          if (!sel_r) rd_nxt = BUS_FLOAT;
          else if (port_r == PORT_DATA) begin
            if (sact_r) begin
              rd_nxt = q_r;
              sidx_nxt = sidx_inc[IW-1:0];
              if (sidx_inc >= SB_C) begin
                sact_nxt = 1'b0;
                sidx_nxt = '0;
                stat.cont_req = 1'b1;
              end
            end else begin
              rd_nxt = rc_r;
            end
          end else if (port_r == PORT_STATUS) rd_nxt = status;
          else rd_nxt = BUS_FLOAT;
        end
        OP_FILL: begin
          if (phase_r == PH_WAIT_RD && bi_ok) begin
            we = 1'b1;
            wa = base + AW'(bi_r);
            wd = val_r;
          end
        end
        OP_DRAIN: if (bi_ok) mb_nxt = q_r;
        OP_DONE: begin
          if (phase_r == PH_WAIT_RD || phase_r == PH_WAIT_WR) begin
            if (merr_r) begin
              err_nxt   = 1'b1;
              rc_nxt    = (phase_r == PH_WAIT_RD) ? RC_READ_ERR : RC_WRITE_ERR;
              phase_nxt = PH_HDR0;
            end else begin
              stat.cont_req = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd.check) begin
      if (!unit_ok) begin
        err_nxt = 1'b1;
        rc_nxt = RC_NOT_READY;
        phase_nxt = PH_HDR0;
      end else if (lsec_r >= total_r) begin
        err_nxt = 1'b1;
        rc_nxt = RC_READ_ERR;
        phase_nxt = PH_HDR0;
      end else begin
        stat.check_pass = 1'b1;
      end
    end

    if (cmd.cont) begin
      if ((hdr_r[0] & CMD_READ) != 8'h00) begin
        hdr_nxt[0] = hdr_r[0] & ~CMD_READ;
        req_nxt = REQ_READ;
        unit_nxt = hdr_r[1][2:0];
        sec_nxt = phys;
        phase_nxt = PH_WAIT_RD;
      end else if ((hdr_r[0] & CMD_SEND) != 8'h00) begin
        hdr_nxt[0] = hdr_r[0] & ~CMD_SEND;
        sidx_nxt = '0;
        sact_nxt = 1'b1;
        phase_nxt = PH_SEND;
      end else if ((hdr_r[0] & CMD_RECV) != 8'h00) begin
        hdr_nxt[0] = hdr_r[0] & ~CMD_RECV;
        ridx_nxt = '0;
        phase_nxt = PH_RECV;
      end else if ((hdr_r[0] & CMD_WRITE) != 8'h00) begin
        hdr_nxt[0] = hdr_r[0] & ~CMD_WRITE;
        req_nxt = REQ_WRITE;
        unit_nxt = hdr_r[1][2:0];
        sec_nxt = phys;
        phase_nxt = PH_WAIT_WR;
      end else begin
        phase_nxt = PH_HDR0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    q_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      selc_r  <= 6'd44;
      spc_r   <= 3'd1;
      total_r <= 14'd640;
      ifac_r  <= 4'd7;
      imask_r <= 4'd15;
      units_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SELECT:  selc_r  <= cfg_wdata[5:0];
        CFG_SPC:     spc_r   <= cfg_wdata[2:0];
        CFG_TOTAL:   total_r <= cfg_wdata;
        CFG_IL_FACT: ifac_r  <= cfg_wdata[3:0];
        CFG_IL_MASK: imask_r <= cfg_wdata[3:0];
        CFG_UNITS:   units_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      for (int k = 0; k < 4; k++) hdr_r[k] <= 8'h00;
      err_r   <= 1'b0;
      rc_r    <= 8'h00;
      sidx_r  <= '0;
      sact_r  <= 1'b0;
      ridx_r  <= '0;
      sel_r   <= 1'b0;
      sweep_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      for (int k = 0; k < 4; k++) hdr_r[k] <= hdr_nxt[k];
      err_r  <= err_nxt;
      rc_r   <= rc_nxt;
      sidx_r <= sidx_nxt;
      sact_r <= sact_nxt;
      ridx_r <= ridx_nxt;
      sel_r  <= sel_nxt;
      if (cmd.cont) sweep_r <= '0;
      else if (cmd.clear_en || cmd.wipe_en) sweep_r <= sweep_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_opcode;
      port_r <= in_port;
      val_r  <= in_value;
      bi_r   <= in_byte_index;
      merr_r <= in_media_error;
    end
    if (cmd.addr_load) lsec_r <= lsec_calc;
    rd_r   <= rd_nxt;
    mb_r   <= mb_nxt;
    req_r  <= req_nxt;
    unit_r <= unit_nxt;
    sec_r  <= sec_nxt;
  end

  assign out_read_data     = rd_r;
  assign out_media_request = req_r;
  assign out_media_unit    = unit_r;
  assign out_media_sector  = sec_r;
  assign out_media_byte    = mb_r;
endmodule
`default_nettype wire

// ----- rtl/bdc_ctrl.sv -----
// Controller state machine: sequences item execution, command continuation,
// buffer wipes and the post-reset memory clear. Depends on bdc_pkg.
`default_nettype none
module bdc_ctrl import bdc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output bdc_cmd_t       cmd,
  input  wire bdc_stat_t stat
);
  ctrl_state_t state_r, state_nxt;
  logic        ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    ov_nxt    = ov_r && out_stall;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = ov_r;
        if (in_valid && !ov_r) begin
          cmd.accept = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.hdr_done) state_nxt = ST_HADDR;
        else if (stat.cont_req) state_nxt = ST_CADDR;
        else state_nxt = ST_DONE;
      end
      ST_HADDR: begin
        cmd.addr_load = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = stat.check_pass ? ST_CONT : ST_DONE;
      end
      ST_CADDR: begin
        cmd.addr_load = 1'b1;
        state_nxt = ST_CONT;
      end
      ST_CONT: begin
        cmd.cont = 1'b1;
        state_nxt = stat.cmd_read ? ST_WIPE : ST_DONE;
      end
      ST_WIPE: begin
        cmd.wipe_en = 1'b1;
        if (stat.wipe_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire

// ----- rtl/bus_disk_controller.sv -----
// Sequence: an accepted item is read and executed, then out_valid rises; a completed
// header adds the address load, check and continuation (a failing check skips the
// continuation), a finished transfer or media done adds the address load and
// continuation, and a read-sector step adds the SECTOR_BYTES buffer wipe.
// Flow: one item in flight, the next one taken the cycle after the result is taken.
// Sync reset, then a clear of all BUFFER_COUNT*SECTOR_BYTES memory bytes, in_stall high.
`default_nettype none
module bus_disk_controller import bdc_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [2:0]  in_port,
  input  wire logic [7:0]  in_value,
  input  wire logic [7:0]  in_byte_index,
  input  wire logic        in_media_error,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data,
  output logic [1:0]       out_media_request,
  output logic [2:0]       out_media_unit,
  output logic [13:0]      out_media_sector,
  output logic [7:0]       out_media_byte,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_wdata
);
  bdc_cmd_t  cmd;
  bdc_stat_t stat;

  bdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  bdc_datapath #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_port           (in_port),
    .in_value          (in_value),
    .in_byte_index     (in_byte_index),
    .in_media_error    (in_media_error),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_read_data     (out_read_data),
    .out_media_request (out_media_request),
    .out_media_unit    (out_media_unit),
    .out_media_sector  (out_media_sector),
    .out_media_byte    (out_media_byte)
  );
endmodule
`default_nettype wire

// ----- rtl/bdc_checker.sv -----
// Port-level checker for bus_disk_controller, bound to the top level.
// Uses the macros in bus_disk_controller_assert.svh.
`default_nettype none
`include "bus_disk_controller_assert.svh"
module bdc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_media_request,
  input wire logic [2:0]  out_media_unit,
  input wire logic [13:0] out_media_sector
);
  // memory clear runs right after reset
  `BDC_ASSERT_NEXT(a_clear_stall, !rst_n, in_stall, "input taken during memory clear")
  `BDC_ASSERT_NOW(a_req_code, out_valid, out_media_request != 2'd3, "bad media request code")
  `BDC_ASSERT_NOW(a_no_req_zero, out_valid && out_media_request == 2'd0,
                  out_media_unit == 3'd0 && out_media_sector == 14'd0, "stray request fields")
  `BDC_ASSERT_NEXT(a_hold, rst_n && out_valid && out_stall,
                   out_valid && $stable(out_media_sector), "stalled item changed")
endmodule

bind bus_disk_controller bdc_checker u_bdc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_media_request (out_media_request),
  .out_media_unit    (out_media_unit),
  .out_media_sector  (out_media_sector)
);
`default_nettype wire
